// ===== src/jnc_pkg.sv =====
package jnc_pkg;

    // Default width of the decimal place and exponent counters
    localparam int unsigned COUNT_BITS_DEF = 16;

    // Character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_E_LO  = 8'h65;
    localparam logic [7:0] CH_E_UP  = 8'h45;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    // Grammar position inside one token
    typedef enum logic [3:0] {
        PH_START    = 4'd0,
        PH_MINUS    = 4'd1,
        PH_ZERO     = 4'd2,
        PH_INT      = 4'd3,
        PH_DOT      = 4'd4,
        PH_FRAC     = 4'd5,
        PH_EXP_E    = 4'd6,
        PH_EXP_SIGN = 4'd7,
        PH_EXP_DIG  = 4'd8,
        PH_BAD      = 4'd9
    } phase_t;

    // Single-bit token flags
    typedef struct packed {
        logic exp_neg;
        logic sign_seen;
        logic exp_seen;
    } flags_t;

    // Classification of a finished token
    typedef struct packed {
        logic valid_res;
        logic is_negative;
        logic has_exponent;
        logic is_float;
    } result_t;

endpackage

// ===== src/jnc_parse.sv =====
module jnc_parse #(
    parameter int unsigned COUNT_BITS = jnc_pkg::COUNT_BITS_DEF
) (
    input  jnc_pkg::phase_t               phase,
    input  logic signed [COUNT_BITS-1:0]  dcount,
    input  logic        [COUNT_BITS-1:0]  fpos,
    input  logic        [COUNT_BITS-1:0]  evalue,
    input  jnc_pkg::flags_t               flags,
    input  logic        [7:0]             char_code,
    input  logic                          is_final,
    output jnc_pkg::phase_t               phase_next,
    output logic signed [COUNT_BITS-1:0]  dcount_next,
    output logic        [COUNT_BITS-1:0]  fpos_next,
    output logic        [COUNT_BITS-1:0]  evalue_next,
    output jnc_pkg::flags_t               flags_next,
    output jnc_pkg::result_t              result
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

    logic                     is_digit;
    logic                     is_zero_ch;
    logic                     is_e;
    logic [COUNT_BITS+3:0]    ev_wide;
    logic [COUNT_BITS+3:0]    ev_prod;
    logic [COUNT_BITS-1:0]    ev_step;
    logic [COUNT_BITS-1:0]    fpos_inc;
    jnc_pkg::phase_t          ph;
    logic signed [COUNT_BITS-1:0] dc;
    logic [COUNT_BITS-1:0]    fp;
    logic [COUNT_BITS-1:0]    ev;
    jnc_pkg::flags_t          fl;
    logic signed [COUNT_BITS:0] dc_ext;
    logic signed [COUNT_BITS:0] ev_ext;
    logic signed [COUNT_BITS:0] places;
    logic                     ok;

    // Character classes
    assign is_digit   = char_code inside {[jnc_pkg::CH_ZERO:jnc_pkg::CH_NINE]};
    assign is_zero_ch = (char_code == jnc_pkg::CH_ZERO);
    assign is_e       = (char_code == jnc_pkg::CH_E_LO) || (char_code == jnc_pkg::CH_E_UP);

    // Exponent accumulate: ev*10 + digit, saturated
    assign ev_wide = {4'b0000, evalue};
    assign ev_prod = (ev_wide << 3) + (ev_wide << 1) + {{COUNT_BITS{1'b0}}, char_code[3:0]};
    assign ev_step = (ev_prod > {4'b0000, CNT_MAX}) ? CNT_MAX : ev_prod[COUNT_BITS-1:0];

    // Fraction position increment, saturated
    assign fpos_inc = (fpos == CNT_MAX) ? CNT_MAX : fpos + 1'b1;

    // Grammar step
    always_comb
    begin
        ph = phase;
        dc = dcount;
        fp = fpos;
        ev = evalue;
        fl = flags;
        case (phase)
            jnc_pkg::PH_START,
            jnc_pkg::PH_MINUS:
            begin
                if ((phase == jnc_pkg::PH_START) && (char_code == jnc_pkg::CH_MINUS))
                begin
                    fl.sign_seen = 1'b1;
                    ph = jnc_pkg::PH_MINUS;
                end
                else if (is_zero_ch)
                begin
                    ph = jnc_pkg::PH_ZERO;
                    dc = CNT_MIN;
                end
                else if (is_digit)
                begin
                    ph = jnc_pkg::PH_INT;
                    dc = '0;
                end
                else
                begin
                    ph = jnc_pkg::PH_BAD;
                end
            end
            jnc_pkg::PH_ZERO,
            jnc_pkg::PH_INT:
            begin
                if (is_digit)
                begin
                    if (phase == jnc_pkg::PH_ZERO)
                        ph = jnc_pkg::PH_BAD;
                    else if (is_zero_ch)
                        dc = (dcount == CNT_MIN) ? CNT_MIN : dcount - 1'b1;
                    else
                        dc = '0;
                end
                else if (char_code == jnc_pkg::CH_DOT)
                begin
                    fp = '0;
                    ph = jnc_pkg::PH_DOT;
                end
                else if (is_e)
                begin
                    fl.exp_seen = 1'b1;
                    ph = jnc_pkg::PH_EXP_E;
                end
                else
                begin
                    ph = jnc_pkg::PH_BAD;
                end
            end
            jnc_pkg::PH_DOT,
            jnc_pkg::PH_FRAC:
            begin
                if (is_digit)
                begin
                    fp = fpos_inc;
                    if (!is_zero_ch)
                        dc = fpos_inc;
                    ph = jnc_pkg::PH_FRAC;
                end
                else if (is_e && (phase == jnc_pkg::PH_FRAC))
                begin
                    fl.exp_seen = 1'b1;
                    ph = jnc_pkg::PH_EXP_E;
                end
                else
                begin
                    ph = jnc_pkg::PH_BAD;
                end
            end
            jnc_pkg::PH_EXP_E:
            begin
                if (char_code == jnc_pkg::CH_PLUS)
                begin
                    ph = jnc_pkg::PH_EXP_SIGN;
                end
                else if (char_code == jnc_pkg::CH_MINUS)
                begin
                    fl.exp_neg = 1'b1;
                    ph = jnc_pkg::PH_EXP_SIGN;
                end
                else if (is_digit)
                begin
                    ev = ev_step;
                    ph = jnc_pkg::PH_EXP_DIG;
                end
                else
                begin
                    ph = jnc_pkg::PH_BAD;
                end
            end
            jnc_pkg::PH_EXP_SIGN,
            jnc_pkg::PH_EXP_DIG:
            begin
                if (is_digit)
                begin
                    ev = ev_step;
                    ph = jnc_pkg::PH_EXP_DIG;
                end
                else
                begin
                    ph = jnc_pkg::PH_BAD;
                end
            end
            default:
            begin
                ph = jnc_pkg::PH_BAD;
            end
        endcase
    end

    // Final classification; exponent is zero unless one was seen
    assign dc_ext = {dc[COUNT_BITS-1], dc};
    assign ev_ext = {1'b0, ev};
    assign places = fl.exp_neg ? (dc_ext + ev_ext) : (dc_ext - ev_ext);
    assign ok     = (ph == jnc_pkg::PH_ZERO) || (ph == jnc_pkg::PH_INT) ||
                    (ph == jnc_pkg::PH_FRAC) || (ph == jnc_pkg::PH_EXP_DIG);

    always_comb
    begin
        result.valid_res    = ok;
        result.is_negative  = ok && fl.sign_seen;
        result.has_exponent = ok && fl.exp_seen;
        result.is_float     = ok && !places[COUNT_BITS] && (places != '0);
    end

    // Token state returns to its start values after the last character
    always_comb
    begin
        if (is_final)
        begin
            phase_next  = jnc_pkg::PH_START;
            dcount_next = '0;
            fpos_next   = '0;
            evalue_next = '0;
            flags_next  = '0;
        end
        else
        begin
            phase_next  = ph;
            dcount_next = dc;
            fpos_next   = fp;
            evalue_next = ev;
            flags_next  = fl;
        end
    end

endmodule

// ===== src/json_number_classifier.sv =====
// JSON number classifier.
// Input channel (in_valid/in_ready): one character word per transfer,
// char_code plus is_final on the last character of a token. Output channel
// (out_valid/out_ready): one result word per token, carrying valid_res,
// is_negative, has_exponent and is_float; the last three are 0 when the
// token is malformed.
// Pipeline: an input register, then the grammar step and classification,
// then a result register. Throughput is one character per cycle, except
// while a final character waits for the result register. out_valid rises
// when the final character steps out of the input register into a free
// result register, which then holds the token's result word.
// When the receiver stalls, the result register holds its word; non-final
// characters keep flowing, and a final character waits in the input
// register until the result register can take its word, so at most two
// words are held before in_ready drops.
// Reset (rst_n low, asynchronous) empties both registers and returns the
// parser to the start of a token.
module json_number_classifier #(
    parameter int unsigned COUNT_BITS = jnc_pkg::COUNT_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    input  logic       is_final,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       valid_res,
    output logic       is_negative,
    output logic       has_exponent,
    output logic       is_float
);

    logic                          in_valid_reg;
    logic [7:0]                    char_reg;
    logic                          final_reg;
    logic                          out_valid_reg;
    jnc_pkg::result_t              result_reg;

    jnc_pkg::phase_t               phase_reg;
    jnc_pkg::phase_t               phase_next;
    logic signed [COUNT_BITS-1:0]  dcount_reg;
    logic signed [COUNT_BITS-1:0]  dcount_next;
    logic        [COUNT_BITS-1:0]  fpos_reg;
    logic        [COUNT_BITS-1:0]  fpos_next;
    logic        [COUNT_BITS-1:0]  evalue_reg;
    logic        [COUNT_BITS-1:0]  evalue_next;
    jnc_pkg::flags_t               flags_reg;
    jnc_pkg::flags_t               flags_next;
    jnc_pkg::result_t              result;

    logic out_free;
    logic step;

    // Handshake: a final word steps only when the result register is free
    assign out_free = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && (!final_reg || out_free);
    assign in_ready = !in_valid_reg || step;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            char_reg  <= char_code;
            final_reg <= is_final;
        end
    end

    // Grammar step
    jnc_parse #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parse (
        .phase       (phase_reg),
        .dcount      (dcount_reg),
        .fpos        (fpos_reg),
        .evalue      (evalue_reg),
        .flags       (flags_reg),
        .char_code   (char_reg),
        .is_final    (final_reg),
        .phase_next  (phase_next),
        .dcount_next (dcount_next),
        .fpos_next   (fpos_next),
        .evalue_next (evalue_next),
        .flags_next  (flags_next),
        .result      (result)
    );

    // Token state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= jnc_pkg::PH_START;
            dcount_reg <= '0;
            fpos_reg   <= '0;
            evalue_reg <= '0;
            flags_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            dcount_reg <= dcount_next;
            fpos_reg   <= fpos_next;
            evalue_reg <= evalue_next;
            flags_reg  <= flags_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step && final_reg)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step && final_reg)
            result_reg <= result;
    end

    assign out_valid    = out_valid_reg;
    assign valid_res    = result_reg.valid_res;
    assign is_negative  = result_reg.is_negative;
    assign has_exponent = result_reg.has_exponent;
    assign is_float     = result_reg.is_float;

endmodule
